### rtl/simple_moving_average_core_assert.svh
// Assertion macros shared by the simple moving average RTL.
`ifndef SIMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SMA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sma: same-cycle property violated");

// The antecedent implies the consequent in the next cycle.
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sma: next-cycle property violated");

`endif

### rtl/sma_pkg.sv
// Package with shared constants and types of the simple moving average.
`default_nettype none

package sma_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W = 9;
	localparam int DEF_MAX_WINDOW = 256;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd20;

	typedef struct packed {
		logic start;
		logic full;
	} sma_div_ctl_t;

endpackage

`default_nettype wire

### rtl/sma_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/sma_window.sv
// Window front end: ring memory, fill count, write slot and exact running sum.
`default_nettype none
`include "simple_moving_average_core_assert.svh"

module sma_window import sma_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	localparam int AW = $clog2(MAX_WINDOW),
	localparam int CW = $clog2(MAX_WINDOW + 1),
	localparam int SW = SAMPLE_W + CW
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       div_ready,
	output      sma_div_ctl_t               div_ctl,
	output      logic signed [SW-1:0]       div_sum,
	output      logic [CW-1:0]              div_count
);

	typedef enum logic [1:0] {
		W_IDLE = 2'b01,
		W_READ = 2'b10
	} win_state_t;

	localparam logic [31:0] MAX_W32 = 32'(MAX_WINDOW);

	win_state_t              state_q;
	logic [CFG_W-1:0]        wlen_q;
	logic [AW-1:0]           slot_q;
	logic [CW-1:0]           fill_q;
	logic signed [SW-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0]     ring_rdata;

	logic [31:0]             wlen_ext;
	logic [31:0]             period_ext;
	logic [CW-1:0]           period;
	logic                    accept;
	logic                    full_before;
	logic [CW-1:0]           fill_next;
	logic signed [SW-1:0]    sum_next;
	logic [CW-1:0]           slot_inc;
	logic [AW-1:0]           slot_next;

	always_comb begin
		wlen_ext = 32'(wlen_q);
		if (wlen_ext == 32'd0) begin
			period_ext = 32'd1;
		end else if (wlen_ext > MAX_W32) begin
			period_ext = MAX_W32;
		end else begin
			period_ext = wlen_ext;
		end
		period = period_ext[CW-1:0];
	end

	assign in_ready = (state_q == W_IDLE) && div_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		full_before = (fill_q == period);
		fill_next = full_before ? fill_q : fill_q + CW'(1);
		if (full_before) begin
			sum_next = sum_q + SW'(sample_q) - SW'($signed(ring_rdata));
		end else begin
			sum_next = sum_q + SW'(sample_q);
		end
		slot_inc = CW'(slot_q) + CW'(1);
		slot_next = (slot_inc >= period) ? '0 : slot_inc[AW-1:0];
	end

	assign div_ctl = {(state_q == W_READ), (fill_next == period)};
	assign div_sum = sum_next;
	assign div_count = fill_next;

	sma_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == W_READ),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (accept),
		.raddr(slot_q),
		.rdata(ring_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			wlen_q <= WINDOW_RESET;
			slot_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
		end else begin
			if (cfg_we) begin
				wlen_q <= cfg_data;
				slot_q <= '0;
				fill_q <= '0;
				sum_q <= '0;
			end
			unique case (state_q)
				W_IDLE: begin
					if (accept) begin
						state_q <= W_READ;
					end
				end
				W_READ: begin
					state_q <= W_IDLE;
					slot_q <= slot_next;
					fill_q <= fill_next;
					sum_q <= sum_next;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	`SMA_ASSERT_IMPL(a_start_when_ready, div_ctl.start, div_ready)
	`SMA_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_q <= period)
	`SMA_ASSERT_IMPL(a_slot_bounded, 1'b1, CW'(slot_q) < period)

endmodule

`default_nettype wire

### rtl/sma_div.sv
// Iterative signed divider of the running sum by the sample count, one bit per cycle.
`default_nettype none
`include "simple_moving_average_core_assert.svh"

module sma_div import sma_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	localparam int CW = $clog2(MAX_WINDOW + 1),
	localparam int SW = SAMPLE_W + CW
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sma_div_ctl_t               ctl,
	input  wire logic signed [SW-1:0]       sum,
	input  wire logic [CW-1:0]              count,
	output      logic                       ready,
	output      logic                       res_valid,
	input  wire logic                       res_take,
	output      logic signed [SAMPLE_W-1:0] average,
	output      logic                       full
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_DONE = 3'b100
	} div_state_t;

	localparam int ITER = SAMPLE_W;
	localparam int IW = $clog2(ITER);
	localparam logic [IW-1:0] LAST_ITER = IW'(ITER - 1);

	div_state_t            state_q;
	logic [IW-1:0]         iter_q;
	logic [CW:0]           rem_q;
	logic [SAMPLE_W-1:0]   quo_q;
	logic [CW-1:0]         divisor_q;
	logic                  neg_q;
	logic                  full_q;

	logic [SW-1:0]         mag;
	logic [CW:0]           shifted;
	logic [CW:0]           divisor_ext;
	logic                  ge;

	always_comb begin
		mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
		divisor_ext = {1'b0, divisor_q};
		shifted = {rem_q[CW-1:0], quo_q[SAMPLE_W-1]};
		ge = (shifted >= divisor_ext);
	end

	assign ready = (state_q == D_IDLE);
	assign res_valid = (state_q == D_DONE);
	assign average = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign full = full_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= {1'b0, mag[SW-1:SAMPLE_W]};
			quo_q <= mag[SAMPLE_W-1:0];
			divisor_q <= count;
			neg_q <= sum[SW-1];
			full_q <= ctl.full;
		end else if (state_q == D_RUN) begin
			rem_q <= ge ? shifted - divisor_ext : shifted;
			quo_q <= {quo_q[SAMPLE_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			iter_q <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (ctl.start) begin
						state_q <= D_RUN;
						iter_q <= '0;
					end
				end
				D_RUN: begin
					iter_q <= iter_q + IW'(1);
					if (iter_q == LAST_ITER) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					if (res_take) begin
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	`SMA_ASSERT_IMPL(a_start_idle, ctl.start, state_q == D_IDLE)
	`SMA_ASSERT_NEXT(a_start_runs, ctl.start, state_q == D_RUN)
	`SMA_ASSERT_IMPL(a_rem_below_div, state_q == D_DONE, rem_q < divisor_ext)

endmodule

`default_nettype wire

### rtl/simple_moving_average_core.sv
// Top level of the simple moving average over signed Q16.16 samples.
//
// Channel   Direction  Handshake              Payload
// config    in         window_length_we       window_length
// input     in         in_valid / in_stall    sample
// output    out        out_valid / out_stall  average, window_full
//
// Each accepted sample passes the ring read and sum update, then the divider, which produces
// one quotient bit per cycle, and its result is then loaded into the output register.
// A new sample is accepted only once the divider is free again, after its last result was taken.
// Reset clears the fill count, write slot and running sum; the ring needs no clearing.
// A result stalled at the output does not block the next sample until the divider finishes.
`default_nettype none

module simple_moving_average_core import sma_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       window_length_we,
	input  wire logic [CFG_W-1:0]           window_length,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic signed [SAMPLE_W-1:0] average,
	output      logic                       window_full
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_W + CW;

	logic                       in_ready;
	logic                       div_ready;
	sma_div_ctl_t               div_ctl;
	logic signed [SW-1:0]       div_sum;
	logic [CW-1:0]              div_count;
	logic                       res_valid;
	logic                       res_take;
	logic signed [SAMPLE_W-1:0] res_average;
	logic                       res_full;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic                       full_q;

	assign in_stall = !in_ready;

	sma_window #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (window_length_we),
		.cfg_data (window_length),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.div_ready(div_ready),
		.div_ctl  (div_ctl),
		.div_sum  (div_sum),
		.div_count(div_count)
	);

	sma_div #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.sum      (div_sum),
		.count    (div_count),
		.ready    (div_ready),
		.res_valid(res_valid),
		.res_take (res_take),
		.average  (res_average),
		.full     (res_full)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (res_take) begin
			average_q <= res_average;
			full_q <= res_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign average = average_q;
	assign window_full = full_q;

endmodule

`default_nettype wire
